@@ sv/mf3_pkg.sv @@
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared sizes, types and compare helpers for the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int POS_W      = 8;
  localparam int CFG_W      = 9;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] center_col;
    logic [POS_W-1:0] center_row;
    logic             frame_last;
  } res_meta_t;

  typedef struct packed {
    pix_t      median;
    res_meta_t meta;
  } res_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // last valid index of a dimension, size clamped to 3..hi
  function automatic logic [COL_W-1:0] last_idx(logic [CFG_W-1:0] v, logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] t;
    t = '0;
    if (v < CFG_W'(3)) begin
      t = CFG_W'(2);
    end else if (v > hi) begin
      t = hi - CFG_W'(1);
    end else begin
      t = v - CFG_W'(1);
    end
    return t[COL_W-1:0];
  endfunction

endpackage

@@ sv/mf3_pix_if.sv @@
// ----------------------------------------------------------------------------
// mf3_pix_if
// Pixel input channel: one beat carries one raster-order pixel.
// ----------------------------------------------------------------------------
interface mf3_pix_if import mf3_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;
  logic frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

@@ sv/mf3_res_if.sv @@
// ----------------------------------------------------------------------------
// mf3_res_if
// Result channel: one beat carries one median and its window position.
// ----------------------------------------------------------------------------
interface mf3_res_if import mf3_pkg::*; ();
  logic             valid;
  logic             ready;
  pix_t             median;
  logic [POS_W-1:0] center_col;
  logic [POS_W-1:0] center_row;
  logic             frame_last;

  modport source (output valid, output median, output center_col, output center_row,
                  output frame_last, input ready);
  modport sink (input valid, input median, input center_col, input center_row,
                input frame_last, output ready);
endinterface

@@ sv/mf3_line_buf.sv @@
// ----------------------------------------------------------------------------
// mf3_line_buf
// Raster position counters, two-row line memory and the 3x3 window.
// ----------------------------------------------------------------------------
module mf3_line_buf import mf3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  pix_t             pixel,
  input  logic             frame_start,
  input  logic [COL_W-1:0] w_last,
  input  logic [ROW_W-1:0] h_last,
  output logic             s1_pend,
  output pix_t [8:0]       win,
  output logic             win_vld,
  output res_meta_t        win_meta
);

  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;

  // upper byte: two rows above, lower byte: row above
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;

  logic             s1_vld_r;
  logic             s1_res_r;
  logic             s1_fwd_r;
  pix_t             s1_px_r;
  logic [COL_W-1:0] s1_idx_r;
  res_meta_t        s1_meta_r;
  pix_t             fwd_a_r;
  pix_t             fwd_b_r;
  pix_t             cur_a;
  pix_t             cur_b;
  logic             last_pos;

  pix_t [8:0]       win_r;
  logic             win_vld_r;
  res_meta_t        win_meta_r;

  always_comb begin
    col_cur  = frame_start ? '0 : col_r;
    row_cur  = frame_start ? '0 : row_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    last_pos = (col_cur >= w_last) && (row_cur >= h_last);
    if (acc) begin
      if (col_cur >= w_last) begin
        col_nxt = '0;
        row_nxt = (row_cur >= h_last) ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_nxt = col_cur + COL_W'(1);
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // entry written by the item accepted in the previous cycle is not yet in the read data
  assign cur_a = s1_fwd_r ? fwd_a_r : rd_r[PIX_W-1:0];
  assign cur_b = s1_fwd_r ? fwd_b_r : rd_r[2*PIX_W-1:PIX_W];

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      mem[s1_idx_r] <= {cur_a, s1_px_r};
    end
    rd_r <= mem[col_cur];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_res_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
      s1_res_r <= acc && (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r   <= pixel;
      s1_idx_r  <= col_cur;
      s1_fwd_r  <= s1_vld_r && (s1_idx_r == col_cur);
      fwd_a_r   <= s1_px_r;
      fwd_b_r   <= cur_a;
      s1_meta_r <= '{center_col: POS_W'(col_cur - COL_W'(1)),
                     center_row: POS_W'(row_cur - ROW_W'(1)),
                     frame_last: last_pos};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      win_vld_r <= 1'b0;
    end else begin
      win_vld_r <= s1_vld_r && s1_res_r;
      if (s1_vld_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= cur_b;
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[5] <= cur_a;
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[8] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      win_meta_r <= s1_meta_r;
    end
  end

  assign s1_pend  = s1_vld_r && s1_res_r;
  assign win      = win_r;
  assign win_vld  = win_vld_r;
  assign win_meta = win_meta_r;

endmodule

@@ sv/mf3_median.sv @@
// ----------------------------------------------------------------------------
// mf3_median
// Pipelined median of nine: row sort, column max/median/min, final median of three.
// ----------------------------------------------------------------------------
module mf3_median import mf3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       win_vld,
  input  pix_t [8:0] win,
  input  res_meta_t  win_meta,
  output logic [1:0] pend,
  output logic       res_vld,
  output res_t       res
);

  logic       m1_vld_r;
  pix_t [2:0] lo_r, mid_r, hi_r;
  res_meta_t  m1_meta_r;

  logic       m2_vld_r;
  pix_t       v0_r, v1_r, v2_r;
  res_meta_t  m2_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= win_vld;
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      lo_r[r]  <= min3(win[3*r], win[3*r+1], win[3*r+2]);
      mid_r[r] <= med3(win[3*r], win[3*r+1], win[3*r+2]);
      hi_r[r]  <= max3(win[3*r], win[3*r+1], win[3*r+2]);
    end
    m1_meta_r <= win_meta;
    v0_r      <= max3(lo_r[0], lo_r[1], lo_r[2]);
    v1_r      <= med3(mid_r[0], mid_r[1], mid_r[2]);
    v2_r      <= min3(hi_r[0], hi_r[1], hi_r[2]);
    m2_meta_r <= m1_meta_r;
  end

  assign pend       = 2'(m1_vld_r) + 2'(m2_vld_r);
  assign res_vld    = m2_vld_r;
  assign res.median = med3(v0_r, v1_r, v2_r);
  assign res.meta   = m2_meta_r;

endmodule

@@ sv/mf3_out_fifo.sv @@
// ----------------------------------------------------------------------------
// mf3_out_fifo
// Result queue driving the output channel; absorbs back-pressure.
// ----------------------------------------------------------------------------
module mf3_out_fifo import mf3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  res_t             push_data,
  output logic [CNT_W-1:0] count,
  mf3_res_if.source        res_o
);

  res_t               q_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r;
  logic [FIFO_AW-1:0] rd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               pop;
  res_t               head;

  assign pop = res_o.valid && res_o.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_data;
    end
  end

  assign head             = q_r[rd_r];
  assign count            = cnt_r;
  assign res_o.valid      = (cnt_r != '0);
  assign res_o.median     = head.median;
  assign res_o.center_col = head.meta.center_col;
  assign res_o.center_row = head.meta.center_row;
  assign res_o.frame_last = head.meta.frame_last;

endmodule

@@ sv/median_filter_3x3.sv @@
// A result beat passes the s1 stage, the window register, the m1 and m2 stages and the result queue.
// Throughput: one pixel per cycle while in_ch.ready is high; the line memory is read and written once per pixel,
// with the write of the preceding pixel forwarded when both hit the same column.
// Input is held off only when the 8-entry result queue plus results in flight is full.
// Reset: synchronous active-low; position counters and window cleared, frame width 120,
// height 160. Line memory contents are not cleared.
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster-order 8-bit pixel stream, interior pixels only.
// ----------------------------------------------------------------------------
module median_filter_3x3 import mf3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  mf3_pix_if.sink          in_ch,
  mf3_res_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic             acc;
  logic             s1_pend;
  pix_t [8:0]       win;
  logic             win_vld;
  res_meta_t        win_meta;
  logic [1:0]       med_pend;
  logic             res_vld;
  res_t             res;
  logic [CNT_W-1:0] fifo_cnt;
  logic [CNT_W-1:0] total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(120);
      frame_height_r <= CFG_W'(160);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_last = last_idx(frame_width_r, CFG_W'(MAX_WIDTH));
  assign h_last = ROW_W'(last_idx(frame_height_r, CFG_W'(MAX_HEIGHT)));

  assign total       = fifo_cnt + CNT_W'(s1_pend) + CNT_W'(win_vld) + CNT_W'(med_pend);
  assign in_ch.ready = (total < CNT_W'(FIFO_DEPTH));
  assign acc         = in_ch.valid && in_ch.ready;

  mf3_line_buf u_line_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .pixel       (in_ch.pixel),
    .frame_start (in_ch.frame_start),
    .w_last      (w_last),
    .h_last      (h_last),
    .s1_pend     (s1_pend),
    .win         (win),
    .win_vld     (win_vld),
    .win_meta    (win_meta)
  );

  mf3_median u_median (
    .clk      (clk),
    .rst_n    (rst_n),
    .win_vld  (win_vld),
    .win      (win),
    .win_meta (win_meta),
    .pend     (med_pend),
    .res_vld  (res_vld),
    .res      (res)
  );

  mf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .count     (fifo_cnt),
    .res_o     (out_ch)
  );

endmodule

@@ bench/mf3_median_sb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mf3_median_sb_pkg
// Scoreboard for the 3x3 median filter bench: mirrors the line stores, window
// and raster position, predicts one median per interior window and checks the
// result beats against it in order.
// ----------------------------------------------------------------------------
package mf3_median_sb_pkg;
  import mf3_pkg::*;

  class median_scoreboard;
    pix_t             line_above[MAX_WIDTH];
    pix_t             line_above2[MAX_WIDTH];
    pix_t             window[9];
    int unsigned      col;
    int unsigned      row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    res_t             expected_medians[$];
    int unsigned      fail_count;

    function new();
      foreach (line_above[i]) begin
        line_above[i]  = '0;
        line_above2[i] = '0;
      end
      foreach (window[i]) begin
        window[i] = '0;
      end
      col        = 0;
      row        = 0;
      width_reg  = CFG_W'(120);
      height_reg = CFG_W'(160);
      fail_count = 0;
    endfunction

    static function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
      if (v < 3) begin
        return 3;
      end
      if (v > hi) begin
        return hi;
      end
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      if (idx == CFG_FRAME_WIDTH) begin
        width_reg = v;
      end else begin
        height_reg = v;
      end
    endfunction

    // value with at most four entries below it and at least five at or below it
    function pix_t window_median();
      int unsigned below;
      int unsigned at_or_below;
      for (int i = 0; i < 9; i++) begin
        below       = 0;
        at_or_below = 0;
        for (int k = 0; k < 9; k++) begin
          if (window[k] < window[i]) begin
            below++;
          end
          if (window[k] <= window[i]) begin
            at_or_below++;
          end
        end
        if (below <= 4 && at_or_below >= 5) begin
          return window[i];
        end
      end
      return '0;
    endfunction

    function void note_pixel(pix_t px, logic frame_start);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      res_t        r;
      w = eff_width();
      h = eff_height();
      if (frame_start) begin
        col = 0;
        row = 0;
      end
      slot = col % MAX_WIDTH;
      for (int y = 0; y < 3; y++) begin
        window[y*3]     = window[y*3 + 1];
        window[y*3 + 1] = window[y*3 + 2];
      end
      window[2] = line_above2[slot];
      window[5] = line_above[slot];
      window[8] = px;
      line_above2[slot] = line_above[slot];
      line_above[slot]  = px;

      if (col >= 2 && row >= 2) begin
        r.median          = window_median();
        r.meta.center_col = POS_W'(col - 1);
        r.meta.center_row = POS_W'(row - 1);
        r.meta.frame_last = (col >= w - 1) && (row >= h - 1);
        expected_medians.push_back(r);
      end

      if (col >= w - 1) begin
        col = 0;
        row = (row >= h - 1) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_median(res_t got);
      res_t want;
      if (expected_medians.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result beat: median %0d col %0d row %0d last %0b",
                   got.median, got.meta.center_col, got.meta.center_row,
                   got.meta.frame_last);
        end
        return;
      end
      want = expected_medians.pop_front();
      if (got.median !== want.median || got.meta.center_col !== want.meta.center_col ||
          got.meta.center_row !== want.meta.center_row ||
          got.meta.frame_last !== want.meta.frame_last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result mismatch: expected median %0d col %0d row %0d last %0b",
                   want.median, want.meta.center_col, want.meta.center_row,
                   want.meta.frame_last);
          $display("                 got      median %0d col %0d row %0d last %0b",
                   got.median, got.meta.center_col, got.meta.center_row,
                   got.meta.frame_last);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_medians.size();
    endfunction

    function void close_out();
      if (expected_medians.size() != 0) begin
        $display("%0d expected result beats never arrived", expected_medians.size());
        fail_count += expected_medians.size();
      end
    endfunction
  endclass

endpackage

@@ bench/median_filter_3x3_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median_filter_3x3_tb
// Drives raster-order frames of assorted sizes and pixel patterns through the
// median filter with random gaps on both channels, resizes the frame between
// runs (including clamped and mid-frame shrink cases) and checks every median
// beat against a scoreboard prediction.
// ----------------------------------------------------------------------------
module median_filter_3x3_tb import mf3_pkg::*, mf3_median_sb_pkg::*; ();

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PIXELS = 1550;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int MAX_GAP       = 18;

  typedef enum int {PAT_NOISE, PAT_EXTREME, PAT_NARROW, PAT_FLAT} pix_pat_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  mf3_pix_if pix_if();
  mf3_res_if res_if();

  median_scoreboard median_check;
  int unsigned      idle_cycles = 0;
  int unsigned      pixels_sent = 0;
  bit               src_calm    = 1'b0;
  bit               sink_calm   = 1'b0;
  pix_pat_t         pattern     = PAT_NOISE;
  pix_t             flat_level  = '0;

  median_filter_3x3 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned draw_gap(bit calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic pix_t next_pixel();
    case (pattern)
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_NARROW:  return flat_level + pix_t'($urandom_range(0, 3));
      PAT_FLAT:    return flat_level;
      default:     return pix_t'($urandom);
    endcase
  endfunction

  task automatic pick_pattern();
    int unsigned r;
    r = $urandom_range(0, 7);
    case (r)
      0:       pattern = PAT_EXTREME;
      1:       pattern = PAT_NARROW;
      2:       pattern = PAT_FLAT;
      default: pattern = PAT_NOISE;
    endcase
    flat_level = pix_t'($urandom);
  endtask

  task automatic send_pixel(pix_t px, logic fs);
    int unsigned gap;
    gap = draw_gap(src_calm);
    if ($urandom_range(0, 39) == 0) begin
      src_calm = !src_calm;
    end
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel       <= px;
    pix_if.frame_start <= fs;
    @(posedge clk);
    while (pix_if.ready !== 1'b1) @(posedge clk);
    median_check.note_pixel(px, fs);
    pixels_sent++;
  endtask

  // rows x cols beats; an occasional stray frame start restarts the frame
  task automatic send_rows(int unsigned rows, int unsigned cols, bit fresh);
    logic fs;
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        fs = (fresh && r == 0 && c == 0) || ($urandom_range(0, 299) == 0);
        send_pixel(next_pixel(), fs);
      end
    end
  endtask

  task automatic write_dims(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    median_check.set_reg(CFG_FRAME_WIDTH, w);
    median_check.set_reg(CFG_FRAME_HEIGHT, h);
  endtask

  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (median_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side
  initial begin
    int unsigned gap;
    res_t        got;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = draw_gap(sink_calm);
      if ($urandom_range(0, 39) == 0) begin
        sink_calm = !sink_calm;
      end
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (res_if.valid !== 1'b1) @(posedge clk);
      got.median          = res_if.median;
      got.meta.center_col = res_if.center_col;
      got.meta.center_row = res_if.center_row;
      got.meta.frame_last = res_if.frame_last;
      median_check.check_median(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (pix_if.valid && pix_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned ew;
    int unsigned eh;
    int unsigned part_rows;
    int unsigned part_cols;
    int unsigned frames;

    median_check = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_FRAME_WIDTH;
    cfg_wdata          <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel       <= '0;
    pix_if.frame_start <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both sizes below the minimum: 3x3 frames, one median each
    write_dims(CFG_W'(0), CFG_W'(2));
    pattern    = PAT_FLAT;
    flat_level = 8'hFF;
    send_rows(3, 3, 1'b1);
    // wrapped position without a frame start, then a restart part way in
    pattern = PAT_NOISE;
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    pattern = PAT_EXTREME;
    send_rows(3, 3, 1'b1);

    while (pixels_sent < RANDOM_PIXELS) begin
      settle();
      kind = $urandom_range(0, 19);
      pick_pattern();
      case (kind)
        0, 1: begin
          // wide line, clamped from above when over the widest
          write_dims(CFG_W'($urandom_range(200, 511)), CFG_W'($urandom_range(0, 3)));
          send_rows(3, median_check.eff_width(), 1'b1);
        end
        2, 3: begin
          // height clamped from above, partial frame only
          write_dims(CFG_W'($urandom_range(3, 8)), CFG_W'($urandom_range(257, 511)));
          send_rows($urandom_range(3, 8), median_check.eff_width(), 1'b1);
        end
        4, 5, 6: begin
          // shrink while mid-frame so the position may lie past the new edge
          write_dims(CFG_W'($urandom_range(6, 24)), CFG_W'($urandom_range(5, 12)));
          ew        = median_check.eff_width();
          eh        = median_check.eff_height();
          part_rows = $urandom_range(2, eh - 2);
          part_cols = $urandom_range(0, ew - 1);
          send_rows(part_rows, ew, 1'b1);
          send_rows(1, part_cols, 1'b0);
          settle();
          write_dims(CFG_W'($urandom_range(3, ew - 1)), CFG_W'($urandom_range(3, eh)));
          pick_pattern();
          send_rows($urandom_range(2, 4), median_check.eff_width(), 1'b0);
        end
        default: begin
          write_dims(CFG_W'($urandom_range(0, 24)), CFG_W'($urandom_range(0, 12)));
          ew     = median_check.eff_width();
          eh     = median_check.eff_height();
          frames = $urandom_range(1, 3);
          for (int unsigned f = 0; f < frames; f++) begin
            send_rows(eh, ew, f == 0 || $urandom_range(0, 1) == 1);
            pick_pattern();
          end
        end
      endcase
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    median_check.close_out();
    if (median_check.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
